[design/bdqs_pkg.sv]
// Shared types and constants for the bracket depth and quote scanner.
// Holds character codes, outcome codes, flag and result structs.
// Depends on nothing; bdqs_step, the top level and the testbench import it.
package bdqs_pkg;

  // Default sizing of the scanner.
  localparam int unsigned          MAX_DEPTH_DEF  = 255;
  localparam longint unsigned      MAX_LENGTH_DEF = 64'd65536;

  // Character codes that the scanner reacts to.
  localparam logic [15:0] CH_ROUND_OPEN   = 16'h0028;
  localparam logic [15:0] CH_ROUND_CLOSE  = 16'h0029;
  localparam logic [15:0] CH_SQUARE_OPEN  = 16'h005B;
  localparam logic [15:0] CH_SQUARE_CLOSE = 16'h005D;
  localparam logic [15:0] CH_CURLY_OPEN   = 16'h007B;
  localparam logic [15:0] CH_CURLY_CLOSE  = 16'h007D;
  localparam logic [15:0] CH_DQUOTE       = 16'h0022;
  localparam logic [15:0] CH_SQUOTE       = 16'h0027;
  localparam logic [15:0] CH_BSLASH       = 16'h005C;

  // Outcome codes carried on the result channel.
  localparam logic [2:0] OC_RUNNING      = 3'd0;
  localparam logic [2:0] OC_DEPTH        = 3'd1;
  localparam logic [2:0] OC_UNDERFLOW    = 3'd2;
  localparam logic [2:0] OC_UNTERMINATED = 3'd3;
  localparam logic [2:0] OC_END_FOUND    = 3'd4;
  localparam logic [2:0] OC_END_MISSING  = 3'd5;

  // Single-bit scanner flags that travel together.
  typedef struct packed {
    logic inside_quote;
    logic quote_is_double;
    logic escape_pending;
    logic answer_given;
  } scan_flags_t;

  // One result beat.
  typedef struct packed {
    logic        decided;
    logic [2:0]  outcome;
    logic [8:0]  depth_value;
    logic [15:0] end_position;
  } scan_result_t;

endpackage

[design/bdqs_if.sv]
// Valid/ready channel interfaces for the scanner's input and result beats.
// Depends on nothing but plain logic types.
interface bdqs_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        first_unit;
  logic        last_unit;
  logic [7:0]  start_depth;

  modport source (output valid, code_unit, first_unit, last_unit, start_depth, input ready);
  modport sink   (input valid, code_unit, first_unit, last_unit, start_depth, output ready);
endinterface

interface bdqs_out_if;
  logic        valid;
  logic        ready;
  logic        decided;
  logic [2:0]  outcome;
  logic [8:0]  depth_value;
  logic [15:0] end_position;

  modport source (output valid, decided, outcome, depth_value, end_position, input ready);
  modport sink   (input valid, decided, outcome, depth_value, end_position, output ready);
endinterface

[design/bdqs_step.sv]
// Next-state and result logic for one code unit of the scanner.
// Purely combinational; depends on bdqs_pkg for codes and structs.
module bdqs_step
  import bdqs_pkg::*;
#(
  parameter int unsigned  MAX_DEPTH = MAX_DEPTH_DEF,
  parameter int unsigned  DW        = $clog2(MAX_DEPTH + 1),
  parameter logic [15:0]  IDX_CAP   = 16'hFFFF
) (
  input  logic          end_mode,
  input  logic [15:0]   code_unit,
  input  logic          first_unit,
  input  logic          last_unit,
  input  logic [7:0]    start_depth,
  input  logic [DW-1:0] depth_q,
  input  logic [15:0]   idx_q,
  input  scan_flags_t   flags_q,
  output logic [DW-1:0] depth_d,
  output logic [15:0]   idx_d,
  output scan_flags_t   flags_d,
  output scan_result_t  res
);

  localparam logic [DW-1:0] MAXD = DW'(MAX_DEPTH);

  logic          sd_sat;
  logic [DW-1:0] depth_0;
  logic [15:0]   idx_0;
  scan_flags_t   flags_0;
  logic [DW:0]   depth_p1;
  logic          is_quote;
  logic          opener;
  logic          closer;
  logic          underflow;

  // Load the start of a new string, or keep the running state.
  assign sd_sat = {9'd0, start_depth} > 17'(MAX_DEPTH);

  always_comb begin
    if (first_unit) begin
      if (end_mode) begin
        depth_0 = '0;
      end else if (sd_sat) begin
        depth_0 = MAXD;
      end else begin
        depth_0 = DW'(start_depth);
      end
      idx_0   = '0;
      flags_0 = '0;
    end else begin
      depth_0 = depth_q;
      idx_0   = idx_q;
      flags_0 = flags_q;
    end
  end

  // Character classes.
  assign is_quote = (code_unit == CH_DQUOTE) || (code_unit == CH_SQUOTE);
  assign opener   = (code_unit == CH_CURLY_OPEN) ||
                    (!end_mode && ((code_unit == CH_ROUND_OPEN) ||
                                   (code_unit == CH_SQUARE_OPEN)));
  assign closer   = (code_unit == CH_CURLY_CLOSE) ||
                    (!end_mode && ((code_unit == CH_ROUND_CLOSE) ||
                                   (code_unit == CH_SQUARE_CLOSE)));

  // Main scan step: quotes, nesting, then the end of the string.
  always_comb begin
    depth_d   = depth_0;
    idx_d     = idx_0;
    flags_d   = flags_0;
    underflow = 1'b0;
    res       = '{decided: 1'b0, outcome: OC_RUNNING,
                  depth_value: 9'(depth_0), end_position: 16'd0};
    depth_p1  = '0;

    if (!flags_0.answer_given) begin
      if (idx_0 < IDX_CAP) begin
        idx_d = idx_0 + 16'd1;
      end

      if (flags_0.inside_quote) begin
        if (flags_0.escape_pending) begin
          flags_d.escape_pending = 1'b0;
        end else if (code_unit == (flags_0.quote_is_double ? CH_DQUOTE : CH_SQUOTE)) begin
          flags_d.inside_quote = 1'b0;
        end else if (code_unit == CH_BSLASH) begin
          flags_d.escape_pending = 1'b1;
        end
      end else if (is_quote) begin
        flags_d.inside_quote    = 1'b1;
        flags_d.quote_is_double = (code_unit == CH_DQUOTE);
        flags_d.escape_pending  = 1'b0;
      end else if (opener) begin
        if (depth_0 < MAXD) begin
          depth_d = depth_0 + DW'(1);
        end
      end else if (closer) begin
        if (depth_0 == '0) begin
          underflow = 1'b1;
        end else begin
          depth_d = depth_0 - DW'(1);
        end
      end

      depth_p1 = {1'b0, depth_d} + (DW + 1)'(1);

      if (underflow) begin
        flags_d.answer_given = 1'b1;
        res.decided          = 1'b1;
        res.depth_value      = 9'd0;
        if (end_mode) begin
          res.outcome      = OC_END_FOUND;
          res.end_position = idx_0;
        end else begin
          res.outcome = OC_UNDERFLOW;
        end
      end else if (last_unit) begin
        flags_d.answer_given = 1'b1;
        res.decided          = 1'b1;
        res.depth_value      = 9'(depth_d);
        if (end_mode) begin
          res.outcome = OC_END_MISSING;
        end else if (flags_d.inside_quote) begin
          res.outcome     = OC_UNTERMINATED;
          res.depth_value = 9'(depth_p1);
        end else begin
          res.outcome = OC_DEPTH;
        end
      end else begin
        res.depth_value = 9'(depth_d);
      end
    end
  end

endmodule

[design/bracket_depth_quote_scanner_unit.sv]
// Top level of the bracket depth and quote scanner.
// Depends on bdqs_pkg, the bdqs_in_if/bdqs_out_if channels and bdqs_step.
//
//   Channel  Direction  Handshake        Payload
//   in_ch    input      valid/ready      code_unit, first_unit, last_unit, start_depth
//   out_ch   output     valid/ready      decided, outcome, depth_value, end_position
//   cfg      input      cfg_we (no wait) cfg_wdata = scan_mode
//
// One beat in and one beat out per cycle when both sides flow.
// A result is offered once its input beat has passed the input register,
// then the step logic feeding the result register. The scan state
// closes a loop through bdqs_step and updates once per beat.
// Reset (rst_n low, synchronous) clears the scan state, the mode and both
// valid flags. A stalled result holds both registers; input is refused only
// when both are full and the result is not taken.
module bracket_depth_quote_scanner_unit
  import bdqs_pkg::*;
#(
  parameter int unsigned     MAX_DEPTH  = MAX_DEPTH_DEF,
  parameter longint unsigned MAX_LENGTH = MAX_LENGTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  bdqs_in_if.sink    in_ch,
  bdqs_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic       cfg_wdata
);

  localparam int unsigned     DW      = $clog2(MAX_DEPTH + 1);
  localparam longint unsigned LEN_CAP = (MAX_LENGTH - 1 > 65535) ? 65535 : MAX_LENGTH - 1;
  localparam logic [15:0]     IDX_CAP = 16'(LEN_CAP);

  logic          mode_r;
  logic          s1_valid_r;
  logic [15:0]   s1_code_r;
  logic          s1_first_r;
  logic          s1_last_r;
  logic [7:0]    s1_start_r;
  logic [DW-1:0] depth_r;
  logic [DW-1:0] depth_nxt;
  logic [15:0]   idx_r;
  logic [15:0]   idx_nxt;
  scan_flags_t   flags_r;
  scan_flags_t   flags_nxt;
  scan_result_t  res_nxt;
  scan_result_t  res_r;
  logic          out_valid_r;
  logic          out_free;
  logic          s1_fire;
  logic          in_fire;

  // Handshake: the result register frees when empty or taken.
  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_fire     = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Mode register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_code_r  <= in_ch.code_unit;
      s1_first_r <= in_ch.first_unit;
      s1_last_r  <= in_ch.last_unit;
      s1_start_r <= in_ch.start_depth;
    end
  end

  // Scan step for the beat in the input register.
  bdqs_step #(
    .MAX_DEPTH (MAX_DEPTH),
    .DW        (DW),
    .IDX_CAP   (IDX_CAP)
  ) u_step (
    .end_mode    (mode_r),
    .code_unit   (s1_code_r),
    .first_unit  (s1_first_r),
    .last_unit   (s1_last_r),
    .start_depth (s1_start_r),
    .depth_q     (depth_r),
    .idx_q       (idx_r),
    .flags_q     (flags_r),
    .depth_d     (depth_nxt),
    .idx_d       (idx_nxt),
    .flags_d     (flags_nxt),
    .res         (res_nxt)
  );

  // Scan state advances once per beat that moves to the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      idx_r   <= '0;
      flags_r <= '0;
    end else if (s1_fire) begin
      depth_r <= depth_nxt;
      idx_r   <= idx_nxt;
      flags_r <= flags_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.decided      = res_r.decided;
  assign out_ch.outcome      = res_r.outcome;
  assign out_ch.depth_value  = res_r.depth_value;
  assign out_ch.end_position = res_r.end_position;

  // A beat without a decision always reports the running outcome.
  a_running_undecided: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.decided) |-> (res_r.outcome == OC_RUNNING))
    else $error("undecided beat carries a final outcome");

  // Underflow reports a depth of zero.
  a_underflow_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.outcome == OC_UNDERFLOW) |-> (res_r.depth_value == 9'd0))
    else $error("underflow with nonzero depth");

  // Only a found closing brace carries a position.
  a_position_only_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.end_position != 16'd0) |-> (res_r.outcome == OC_END_FOUND))
    else $error("position given without a found brace");

  // A decided beat leaves the string marked as answered.
  a_decided_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && res_nxt.decided) |=> flags_r.answer_given)
    else $error("decision did not set the answered flag");

endmodule

[tb/sv/tb_bracket_depth_quote_scanner_unit.sv]
// Self-checking testbench for bracket_depth_quote_scanner_unit.
// Depends on bdqs_pkg and the bdqs_in_if/bdqs_out_if channel interfaces.
// A built-in scan predictor checks every result beat in order of arrival.
module tb_bracket_depth_quote_scanner_unit;
  import bdqs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [15:0] CH_LETTER_A = 16'h0061;
  localparam int          PHASE_UNITS = 165;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  bdqs_in_if  in_ch();
  bdqs_out_if out_ch();

  bracket_depth_quote_scanner_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Predicted scanner state and the mode register copy.
  logic        mode_q;
  logic [7:0]  depth_q;
  logic        in_quote_q;
  logic        dquote_q;
  logic        escape_q;
  logic        answered_q;
  logic [15:0] index_q;

  scan_result_t awaited_results[$];
  int           scanned_units;
  int           mismatch_count;
  int           send_idle_pct;
  int           recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // Works out the result of one accepted beat and advances the predicted state.
  function automatic scan_result_t predict_scan(logic [15:0] cu, logic fu, logic lu,
                                                logic [7:0] sd);
    scan_result_t r;
    logic [15:0]  pos;
    logic         opener;
    logic         closer;
    r = '0;
    scanned_units++;
    if (fu) begin
      depth_q    = mode_q ? 8'd0 : sd;
      in_quote_q = 1'b0;
      dquote_q   = 1'b0;
      escape_q   = 1'b0;
      answered_q = 1'b0;
      index_q    = 16'd0;
    end
    // Once decided, the rest of the string only shows the frozen depth.
    if (answered_q) begin
      r.depth_value = {1'b0, depth_q};
      return r;
    end
    pos = index_q;
    if (index_q != 16'hFFFF) index_q = index_q + 16'd1;

    if (in_quote_q) begin
      if (escape_q) escape_q = 1'b0;
      else if (cu == (dquote_q ? CH_DQUOTE : CH_SQUOTE)) in_quote_q = 1'b0;
      else if (cu == CH_BSLASH) escape_q = 1'b1;
    end else if (cu == CH_DQUOTE || cu == CH_SQUOTE) begin
      in_quote_q = 1'b1;
      dquote_q   = (cu == CH_DQUOTE);
      escape_q   = 1'b0;
    end else begin
      // End mode counts curly braces only.
      opener = (cu == CH_CURLY_OPEN) ||
               (!mode_q && (cu == CH_ROUND_OPEN || cu == CH_SQUARE_OPEN));
      closer = (cu == CH_CURLY_CLOSE) ||
               (!mode_q && (cu == CH_ROUND_CLOSE || cu == CH_SQUARE_CLOSE));
      if (opener) begin
        if (int'(depth_q) < MAX_DEPTH_DEF) depth_q = depth_q + 8'd1;
      end else if (closer) begin
        if (depth_q == 8'd0) begin
          answered_q = 1'b1;
          r.decided  = 1'b1;
          if (mode_q) begin
            r.outcome      = OC_END_FOUND;
            r.end_position = pos;
          end else begin
            r.outcome = OC_UNDERFLOW;
          end
          return r;
        end
        depth_q = depth_q - 8'd1;
      end
    end

    r.depth_value = {1'b0, depth_q};
    if (lu) begin
      answered_q = 1'b1;
      r.decided  = 1'b1;
      if (mode_q) begin
        r.outcome = OC_END_MISSING;
      end else if (in_quote_q) begin
        r.outcome     = OC_UNTERMINATED;
        r.depth_value = {1'b0, depth_q} + 9'd1;
      end else begin
        r.outcome = OC_DEPTH;
      end
    end
    return r;
  endfunction

  // Sends one beat, with random idle cycles ahead of it. Called right after a rising edge.
  task automatic send_unit(logic [15:0] cu, logic fu, logic lu, logic [7:0] sd);
    logic taken;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.code_unit   <= cu;
    in_ch.first_unit  <= fu;
    in_ch.last_unit   <= lu;
    in_ch.start_depth <= sd;
    // Ready is stable mid-cycle, so sample it on the falling edge.
    do begin
      @(negedge clk);
      taken = in_ch.ready;
      @(posedge clk);
    end while (taken !== 1'b1);
    awaited_results.push_back(predict_scan(cu, fu, lu, sd));
  endtask

  // Lowers valid and waits until every expected result has arrived.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes scan_mode; only called while the scanner is idle.
  task automatic write_mode(logic m);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    mode_q = m;
  endtask

  task automatic compare_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t %s: expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Receiver side: random stalls on the result channel.
  always @(posedge clk) begin
    out_ch.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  // Checks each result beat against the oldest expectation.
  always @(negedge clk) begin
    scan_result_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (awaited_results.size() == 0) begin
        $display("%0t unexpected result beat: expected none, got outcome %0d", $time,
                 out_ch.outcome);
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        if ($isunknown({out_ch.decided, out_ch.outcome, out_ch.depth_value,
                        out_ch.end_position})) begin
          $display("%0t unknown bits in result: expected %h, got %b", $time, want,
                   {out_ch.decided, out_ch.outcome, out_ch.depth_value, out_ch.end_position});
          mismatch_count++;
        end else begin
          compare_field("decided", want.decided, out_ch.decided);
          compare_field("outcome", want.outcome, out_ch.outcome);
          compare_field("depth_value", want.depth_value, out_ch.depth_value);
          compare_field("end_position", want.end_position, out_ch.end_position);
        end
      end
    end
  end

  // Without any first unit the scanner behaves as a string at depth zero.
  task automatic test_no_first_after_reset();
    send_unit(CH_ROUND_OPEN, 1'b0, 1'b0, 8'd0);
    send_unit(CH_LETTER_A, 1'b0, 1'b0, 8'd0);
    send_unit(CH_ROUND_CLOSE, 1'b0, 1'b0, 8'd0);
    send_unit(CH_SQUARE_CLOSE, 1'b0, 1'b0, 8'd0);
    send_unit(CH_CURLY_OPEN, 1'b0, 1'b1, 8'd0);
    drain_results();
  endtask

  // Field extremes, depth saturation and underflow in depth mode.
  task automatic test_depth_edges();
    write_mode(1'b0);
    send_unit(16'hFFFF, 1'b1, 1'b1, 8'd0);
    send_unit(16'h0000, 1'b1, 1'b1, 8'hFF);
    send_unit(CH_CURLY_OPEN, 1'b1, 1'b0, 8'hFF);
    send_unit(CH_SQUARE_OPEN, 1'b0, 1'b0, 8'h00);
    send_unit(CH_ROUND_CLOSE, 1'b0, 1'b1, 8'h00);
    send_unit(CH_SQUARE_CLOSE, 1'b1, 1'b1, 8'd0);
    drain_results();
  endtask

  // Quoted runs with escapes, mixed quote kinds and unterminated quotes.
  task automatic test_quote_skipping();
    send_unit(CH_DQUOTE, 1'b1, 1'b0, 8'd0);
    send_unit(CH_ROUND_OPEN, 1'b0, 1'b0, 8'd0);
    send_unit(CH_BSLASH, 1'b0, 1'b0, 8'd0);
    send_unit(CH_DQUOTE, 1'b0, 1'b0, 8'd0);
    send_unit(CH_SQUOTE, 1'b0, 1'b0, 8'd0);
    send_unit(CH_DQUOTE, 1'b0, 1'b0, 8'd0);
    send_unit(CH_ROUND_CLOSE, 1'b0, 1'b0, 8'd0);
    send_unit(CH_LETTER_A, 1'b0, 1'b1, 8'd0);
    send_unit(CH_SQUOTE, 1'b1, 1'b0, 8'd7);
    send_unit(CH_BSLASH, 1'b0, 1'b0, 8'd0);
    send_unit(CH_SQUOTE, 1'b0, 1'b1, 8'd0);
    send_unit(CH_DQUOTE, 1'b1, 1'b1, 8'hFF);
    drain_results();
  endtask

  // End mode: start depth ignored, quotes skipped, round brackets not counted.
  task automatic test_end_mode();
    write_mode(1'b1);
    send_unit(CH_CURLY_OPEN, 1'b1, 1'b0, 8'd200);
    send_unit(CH_DQUOTE, 1'b0, 1'b0, 8'd0);
    send_unit(CH_CURLY_CLOSE, 1'b0, 1'b0, 8'd0);
    send_unit(CH_DQUOTE, 1'b0, 1'b0, 8'd0);
    send_unit(CH_CURLY_CLOSE, 1'b0, 1'b0, 8'd0);
    send_unit(CH_CURLY_CLOSE, 1'b0, 1'b0, 8'd0);
    send_unit(CH_LETTER_A, 1'b0, 1'b1, 8'd0);
    send_unit(CH_ROUND_OPEN, 1'b1, 1'b0, 8'd5);
    send_unit(CH_ROUND_CLOSE, 1'b0, 1'b1, 8'd0);
    send_unit(CH_SQUOTE, 1'b1, 1'b1, 8'd0);
    drain_results();
  endtask

  // The mode changes between beats of one string and applies from the next beat.
  task automatic test_mode_switch_mid_string();
    write_mode(1'b0);
    send_unit(CH_ROUND_OPEN, 1'b1, 1'b0, 8'd3);
    drain_results();
    write_mode(1'b1);
    send_unit(CH_ROUND_OPEN, 1'b0, 1'b0, 8'd0);
    send_unit(CH_CURLY_CLOSE, 1'b0, 1'b0, 8'd0);
    drain_results();
    write_mode(1'b0);
    send_unit(CH_ROUND_CLOSE, 1'b0, 1'b1, 8'd0);
    drain_results();
  endtask

  // A longer string in end mode; the found position counts every unit before it.
  task automatic test_long_string();
    write_mode(1'b1);
    send_unit(CH_LETTER_A, 1'b1, 1'b0, 8'd0);
    for (int k = 1; k <= 30; k++) send_unit(CH_LETTER_A, 1'b0, 1'b0, 8'd0);
    send_unit(CH_CURLY_CLOSE, 1'b0, 1'b1, 8'd0);
    drain_results();
  endtask

  // One random string, mostly balanced, with quotes, escapes and noise.
  task automatic send_random_string();
    int          len;
    int          open_count;
    int          pick;
    logic [15:0] cu;
    logic [7:0]  sd;
    logic        drop_last;
    len = ($urandom_range(15) == 0) ? $urandom_range(80, 40) : $urandom_range(20, 1);
    case ($urandom_range(3))
      0:       sd = 8'd0;
      1:       sd = 8'hFF;
      2:       sd = 8'($urandom_range(3));
      default: sd = 8'($urandom_range(255));
    endcase
    drop_last  = ($urandom_range(9) == 0);
    open_count = mode_q ? 0 : int'(sd);
    for (int k = 0; k < len; k++) begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        case ($urandom_range(2))
          0:       cu = CH_ROUND_OPEN;
          1:       cu = CH_SQUARE_OPEN;
          default: cu = CH_CURLY_OPEN;
        endcase
        open_count++;
      end else if (pick < 35 && (open_count > 0 || $urandom_range(9) == 0)) begin
        case ($urandom_range(2))
          0:       cu = CH_ROUND_CLOSE;
          1:       cu = CH_SQUARE_CLOSE;
          default: cu = CH_CURLY_CLOSE;
        endcase
        if (open_count > 0) open_count--;
      end else if (pick < 43) begin
        cu = CH_DQUOTE;
      end else if (pick < 51) begin
        cu = CH_SQUOTE;
      end else if (pick < 57) begin
        cu = CH_BSLASH;
      end else if (pick < 92) begin
        cu = CH_LETTER_A + 16'($urandom_range(25));
      end else begin
        cu = 16'($urandom_range(16'hFFFF));
      end
      send_unit(cu, k == 0, (k == len - 1) && !drop_last,
                (k == 0) ? sd : 8'($urandom_range(255)));
    end
    // Occasional trailing beats with no new string started.
    if ($urandom_range(7) == 0) begin
      repeat ($urandom_range(3, 1))
        send_unit(16'($urandom_range(16'hFFFF)), 1'b0, 1'($urandom_range(1)),
                  8'($urandom_range(255)));
    end
  endtask

  // Random strings in both modes under each idling pattern.
  task automatic test_random_traffic();
    int idle_pattern[4][2] = '{'{0, 0}, '{86, 0}, '{0, 86}, '{12, 12}};
    for (int p = 0; p < 8; p++) begin
      write_mode(1'(p));
      send_idle_pct  = idle_pattern[p / 2][0];
      recv_stall_pct = idle_pattern[p / 2][1];
      scanned_units  = 0;
      while (scanned_units < PHASE_UNITS) send_random_string();
      drain_results();
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.code_unit   = 16'd0;
    in_ch.first_unit  = 1'b0;
    in_ch.last_unit   = 1'b0;
    in_ch.start_depth = 8'd0;
    out_ch.ready      = 1'b0;
    mode_q            = 1'b0;
    depth_q           = 8'd0;
    in_quote_q        = 1'b0;
    dquote_q          = 1'b0;
    escape_q          = 1'b0;
    answered_q        = 1'b0;
    index_q           = 16'd0;
    scanned_units     = 0;
    mismatch_count    = 0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_no_first_after_reset();
    test_depth_edges();
    test_quote_skipping();
    test_end_mode();
    test_mode_switch_mid_string();
    test_long_string();
    test_random_traffic();

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[files.f]
design/bdqs_pkg.sv
design/bdqs_if.sv
design/bdqs_step.sv
design/bracket_depth_quote_scanner_unit.sv
tb/sv/tb_bracket_depth_quote_scanner_unit.sv
